FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/u8s_pkg.sv
package u8s_pkg;

  // Input beat: one raw string byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } u8s_in_t;

  // Output beat: one sanitized byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } u8s_out_t;

  // Byte class masks and patterns
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  // U+FFFD replacement character
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

endpackage

FILE: rtl/utf8_sanitizer.sv
// The first output beat is registered once the accepted byte has put the block in
// its emit state and the slot is free. A byte that yields N output bytes (0..12)
// keeps in_ready low until all N are sent, one per cycle unless out_ready stalls,
// from a shared emit counter and byte mux. A held-back lead or continuation byte
// yields nothing. Reset (synchronous, rst_n low) clears pending state and out_valid.
module utf8_sanitizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8s_pkg::u8s_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output u8s_pkg::u8s_out_t out_data
);
  import u8s_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic       state_r;
  logic [7:0] lead_held_r;
  logic [7:0] cont_held_r [2];
  logic [1:0] held_count_r;
  logic [2:0] needed_total_r;

  // Emit sequencer
  logic [2:0] rep_left_r;
  logic [1:0] rep_pos_r;
  logic [3:0] total_r;
  logic       last_r;
  logic [7:0] tail_r [4];

  logic       out_valid_r;
  u8s_out_t   out_data_r;

  // Accept-time decode
  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       is_cont;
  logic       pending;
  logic       complete;
  logic       fresh_ascii;
  logic       fresh_rep;
  logic [2:0] fresh_need;
  logic [2:0] reps_nxt;
  logic [2:0] tail_cnt_nxt;
  logic [7:0] tail_nxt [4];
  logic [3:0] total_nxt;
  logic       store_cont;
  logic [7:0] lead_held_nxt;
  logic [1:0] held_count_nxt;
  logic [2:0] needed_total_nxt;
  logic       slot_free;
  logic [7:0] emit_byte;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign b         = in_data.data_byte;
  assign last      = in_data.end_of_string;
  assign is_cont   = ((b & MASK_CONT) == PAT_CONT);
  assign pending   = (needed_total_r != 3'd0);
  assign complete  = (({1'b0, held_count_r} + 3'd1) == needed_total_r);
  assign slot_free = !out_valid_r || out_ready;

  // Classify a byte seen with nothing pending
  always_comb begin
    fresh_ascii = (b[7] == 1'b0);
    fresh_need  = 3'd0;
    priority if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      fresh_need = 3'd1;
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      fresh_need = 3'd2;
    end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
      fresh_need = 3'd3;
    end else begin
      fresh_need = 3'd0;
    end
    fresh_rep = !fresh_ascii && ((fresh_need == 3'd0) || last);
  end

  // Plan the output run and the next pending state
  always_comb begin
    reps_nxt         = 3'd0;
    tail_cnt_nxt     = 3'd0;
    tail_nxt[0]      = b;
    tail_nxt[1]      = b;
    tail_nxt[2]      = b;
    tail_nxt[3]      = b;
    store_cont       = 1'b0;
    lead_held_nxt    = lead_held_r;
    held_count_nxt   = held_count_r;
    needed_total_nxt = needed_total_r;

    if (pending && is_cont) begin
      if (complete) begin
        // Replay the whole sequence
        tail_nxt[0]      = lead_held_r;
        tail_nxt[1]      = (held_count_r == 2'd0) ? b : cont_held_r[0];
        tail_nxt[2]      = (held_count_r == 2'd2) ? cont_held_r[1] : b;
        tail_nxt[3]      = b;
        tail_cnt_nxt     = {1'b0, held_count_r} + 3'd2;
        lead_held_nxt    = 8'h00;
        held_count_nxt   = 2'd0;
        needed_total_nxt = 3'd0;
      end else if (last) begin
        // Cut short: lead, held bytes and this byte all replaced
        reps_nxt         = {1'b0, held_count_r} + 3'd2;
        lead_held_nxt    = 8'h00;
        held_count_nxt   = 2'd0;
        needed_total_nxt = 3'd0;
      end else begin
        store_cont     = 1'b1;
        held_count_nxt = held_count_r + 2'd1;
      end
    end else begin
      // Broken sequence (if any), then scan this byte fresh
      reps_nxt   = (pending ? ({1'b0, held_count_r} + 3'd1) : 3'd0)
                   + {2'b00, fresh_rep};
      tail_cnt_nxt = {2'b00, fresh_ascii};
      if (!fresh_ascii && (fresh_need != 3'd0) && !last) begin
        lead_held_nxt    = b;
        held_count_nxt   = 2'd0;
        needed_total_nxt = fresh_need;
      end else begin
        lead_held_nxt    = 8'h00;
        held_count_nxt   = 2'd0;
        needed_total_nxt = 3'd0;
      end
    end

    if (last) begin
      lead_held_nxt    = 8'h00;
      held_count_nxt   = 2'd0;
      needed_total_nxt = 3'd0;
    end

    total_nxt = {1'b0, reps_nxt} + {reps_nxt, 1'b0} + {1'b0, tail_cnt_nxt};
  end

  // Byte for the current emit step
  always_comb begin
    if (rep_left_r != 3'd0) begin
      unique case (rep_pos_r)
        2'd0:    emit_byte = REPL_B0;
        2'd1:    emit_byte = REPL_B1;
        default: emit_byte = REPL_B2;
      endcase
    end else begin
      emit_byte = tail_r[0];
    end
  end

  // Control and pending state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      lead_held_r    <= 8'h00;
      held_count_r   <= 2'd0;
      needed_total_r <= 3'd0;
      rep_left_r     <= 3'd0;
      rep_pos_r      <= 2'd0;
      total_r        <= 4'd0;
      last_r         <= 1'b0;
    end else begin
      // While emitting, a taken slot is refilled below
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        lead_held_r    <= lead_held_nxt;
        held_count_r   <= held_count_nxt;
        needed_total_r <= needed_total_nxt;
        rep_left_r     <= reps_nxt;
        rep_pos_r      <= 2'd0;
        total_r        <= total_nxt;
        last_r         <= last;
        if (total_nxt != 4'd0) begin
          state_r <= ST_EMIT;
        end
      end
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
        total_r     <= total_r - 4'd1;
        if (rep_left_r != 3'd0) begin
          if (rep_pos_r == 2'd2) begin
            rep_pos_r  <= 2'd0;
            rep_left_r <= rep_left_r - 3'd1;
          end else begin
            rep_pos_r <= rep_pos_r + 2'd1;
          end
        end
        if (total_r == 4'd1) begin
          state_r <= ST_IDLE;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && store_cont) begin
      cont_held_r[held_count_r[0]] <= b;
    end
    if (accept) begin
      tail_r[0] <= tail_nxt[0];
      tail_r[1] <= tail_nxt[1];
      tail_r[2] <= tail_nxt[2];
      tail_r[3] <= tail_nxt[3];
    end else if ((state_r == ST_EMIT) && slot_free && (rep_left_r == 3'd0)) begin
      // Shift the replay queue one byte
      tail_r[0] <= tail_r[1];
      tail_r[1] <= tail_r[2];
      tail_r[2] <= tail_r[3];
    end
    if ((state_r == ST_EMIT) && slot_free) begin
      out_data_r.out_byte   <= emit_byte;
      out_data_r.run_end    <= (total_r == 4'd1);
      out_data_r.string_end <= (total_r == 4'd1) && last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/u8s_checker.sv
`include "assert_macros.svh"

module u8s_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input u8s_pkg::u8s_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input u8s_pkg::u8s_out_t out_data
);
  import u8s_pkg::*;

  // A stalled output beat stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // The string's last byte also closes its run
  `ASSERT_IMPLIES(a_str_end_run, clk, rst_n, out_valid && out_data.string_end, out_data.run_end)

  // A final byte always produces output, so the block goes busy
  `ASSERT_NEXT(a_final_busy, clk, rst_n, in_valid && in_ready && in_data.end_of_string, !in_ready)

  // Reset empties the output register
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

endmodule

bind utf8_sanitizer u8s_checker u_u8s_checker (.*);
